// ===== rtl/core/ric_pkg.sv =====
`timescale 1ns / 1ps

package ric_pkg;

  localparam int DEFAULT_ENTRIES = 64;
  localparam int INODE_W = 16;
  localparam int REFS_W = 16;
  localparam int SLOT_W = 6;

  typedef enum logic [1:0] {
    OP_ACQUIRE = 2'd0,
    OP_RELEASE = 2'd1,
    OP_CLEAR   = 2'd2
  } op_t;

  typedef enum logic [2:0] {
    ST_HIT    = 3'd0,
    ST_ALLOC  = 3'd1,
    ST_FULL   = 3'd2,
    ST_REJECT = 3'd3,
    ST_HELD   = 3'd4,
    ST_EVICT  = 3'd5,
    ST_IGNORE = 3'd6,
    ST_CLEAR  = 3'd7
  } status_t;

  localparam logic CFG_MOUNTED = 1'b0;
  localparam logic CFG_ROOT    = 1'b1;

  localparam logic [INODE_W-1:0] ROOT_RESET = 16'd1;
  localparam logic [REFS_W-1:0]  REFS_MAX   = 16'hFFFF;

  typedef struct packed {
    logic               valid;
    logic [INODE_W-1:0] inode;
    logic [REFS_W-1:0]  refs;
  } entry_t;

endpackage

// ===== rtl/core/refcounted_inode_cache.sv =====
`timescale 1ns / 1ps

// Channel | Direction | Signals
// in      | sink      | in_valid, in_ready, operation, inode_number, entry_modified, no_links
// out     | source    | out_valid, out_ready, status, slot, ref_count, writeback_needed,
//         |           | free_inode_request
// cfg     | sink      | cfg_valid, cfg_ready, cfg_index, cfg_data
//
// Acquire and release scan every slot before their result: one shared
// comparator walks the entry memory one slot per cycle through its
// registered read port, then one shared adder updates the chosen entry.
// Clear writes the entry memory once per slot.
// Rejected acquires and unknown operations skip the scan and go to the result.
// After reset a clearing pass over every slot runs before in_ready rises;
// configuration writes are taken at any time.
// While a result waits for out_ready, one more beat is taken and processed;
// its result then holds the block until the waiting one is taken.
module refcounted_inode_cache #(
  parameter int CACHE_ENTRIES = ric_pkg::DEFAULT_ENTRIES
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [1:0]                   operation,
  input  logic [ric_pkg::INODE_W-1:0]  inode_number,
  input  logic                         entry_modified,
  input  logic                         no_links,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [2:0]                   status,
  output logic [ric_pkg::SLOT_W-1:0]   slot,
  output logic [ric_pkg::REFS_W-1:0]   ref_count,
  output logic                         writeback_needed,
  output logic                         free_inode_request,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic                         cfg_index,
  input  logic [ric_pkg::INODE_W-1:0]  cfg_data
);

  localparam int IDX_W = $clog2(CACHE_ENTRIES);
  localparam int CNT_W = $clog2(CACHE_ENTRIES + 1);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(CACHE_ENTRIES - 1);
  localparam logic [CNT_W-1:0] SCAN_END = CNT_W'(CACHE_ENTRIES);

  typedef enum logic [2:0] {
    S_SWEEP,
    S_IDLE,
    S_SCAN,
    S_UPDATE,
    S_EMIT
  } state_t;

  state_t state;

  logic                        mounted;
  logic [ric_pkg::INODE_W-1:0] root_inode;
  logic                        clr_pending;
  logic [IDX_W-1:0]            sweep_cnt;
  logic [CNT_W-1:0]            scan_cnt;

  ric_pkg::op_t                op_q;
  logic [ric_pkg::INODE_W-1:0] ino_q;
  logic                        mod_q;
  logic                        nolinks_q;

  logic                        rd_pend;
  logic [IDX_W-1:0]            rd_idx;
  ric_pkg::entry_t             rd_data;

  logic                        hit_found;
  logic [IDX_W-1:0]            hit_idx;
  logic [ric_pkg::REFS_W-1:0]  hit_refs;
  logic                        free_found;
  logic [IDX_W-1:0]            free_idx;

  ric_pkg::status_t            res_status;
  logic [IDX_W-1:0]            res_slot;
  logic [ric_pkg::REFS_W-1:0]  res_refs;
  logic                        res_wb;
  logic                        res_fr;

  ric_pkg::status_t            out_status;
  logic [ric_pkg::SLOT_W-1:0]  out_slot;
  logic [ric_pkg::REFS_W-1:0]  out_refs;
  logic                        out_wb;
  logic                        out_fr;

  ric_pkg::entry_t             mem [CACHE_ENTRIES];
  logic                        rd_en;
  logic                        wr_en;
  logic [IDX_W-1:0]            wr_addr;
  ric_pkg::entry_t             wr_data;

  ric_pkg::status_t            upd_status;
  logic [IDX_W-1:0]            upd_slot;
  logic [ric_pkg::REFS_W-1:0]  upd_refs;
  logic                        upd_wb;
  logic                        upd_fr;
  logic                        upd_we;
  ric_pkg::entry_t             upd_entry;
  logic                        upd_acq;
  logic [ric_pkg::REFS_W-1:0]  upd_sum;
  logic [IDX_W+ric_pkg::SLOT_W-1:0] slot_wide;

  assign in_ready  = (state == S_IDLE);
  assign cfg_ready = 1'b1;

  assign status             = out_status;
  assign slot               = out_slot;
  assign ref_count          = out_refs;
  assign writeback_needed   = out_wb;
  assign free_inode_request = out_fr;

  assign rd_en     = (state == S_SCAN) && (scan_cnt != SCAN_END);
  assign slot_wide = {{ric_pkg::SLOT_W{1'b0}}, res_slot};

  // The one adder serves both the increment of an acquire and the decrement
  // of a release.
  assign upd_acq = (op_q == ric_pkg::OP_ACQUIRE);
  assign upd_sum = hit_refs + (upd_acq ? 16'h0001 : 16'hFFFF);

  always_comb begin
    upd_status = ric_pkg::ST_IGNORE;
    upd_slot   = '0;
    upd_refs   = '0;
    upd_wb     = 1'b0;
    upd_fr     = 1'b0;
    upd_we     = 1'b0;
    upd_entry  = '{valid: 1'b1, inode: ino_q, refs: 16'd1};
    if (upd_acq) begin
      if (hit_found) begin
        upd_status = ric_pkg::ST_HIT;
        upd_slot   = hit_idx;
        upd_refs   = (hit_refs == ric_pkg::REFS_MAX) ? hit_refs : upd_sum;
        upd_we     = 1'b1;
        upd_entry.refs = upd_refs;
      end else if (free_found) begin
        upd_status = ric_pkg::ST_ALLOC;
        upd_slot   = free_idx;
        upd_refs   = 16'd1;
        upd_we     = 1'b1;
      end else begin
        upd_status = ric_pkg::ST_FULL;
      end
    end else if (hit_found && (hit_refs != '0)) begin
      upd_slot = hit_idx;
      upd_we   = 1'b1;
      if (upd_sum != '0) begin
        upd_status     = ric_pkg::ST_HELD;
        upd_refs       = upd_sum;
        upd_entry.refs = upd_sum;
      end else begin
        upd_status      = ric_pkg::ST_EVICT;
        upd_entry.valid = 1'b0;
        upd_entry.refs  = '0;
        upd_wb          = mod_q;
        upd_fr          = nolinks_q && mounted && (ino_q != '0) && (ino_q != root_inode);
      end
    end
  end

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = sweep_cnt;
    wr_data = '0;
    if (state == S_SWEEP) begin
      wr_en = 1'b1;
    end else if (state == S_UPDATE) begin
      wr_en   = upd_we;
      wr_addr = upd_slot;
      wr_data = upd_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[scan_cnt[IDX_W-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_SWEEP;
      sweep_cnt   <= '0;
      clr_pending <= 1'b0;
      rd_pend     <= 1'b0;
      out_valid   <= 1'b0;
      mounted     <= 1'b0;
      root_inode  <= ric_pkg::ROOT_RESET;
    end else begin
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          ric_pkg::CFG_MOUNTED: mounted <= cfg_data[0];
          ric_pkg::CFG_ROOT:    root_inode <= cfg_data;
          default: ;
        endcase
      end

      if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end

      rd_pend <= 1'b0;

      unique case (state)
        S_SWEEP: begin
          sweep_cnt <= sweep_cnt + 1'b1;
          if (sweep_cnt == LAST_IDX) begin
            sweep_cnt   <= '0;
            clr_pending <= 1'b0;
            if (clr_pending) begin
              res_status <= ric_pkg::ST_CLEAR;
              state      <= S_EMIT;
            end else begin
              state <= S_IDLE;
            end
          end
        end

        S_IDLE: begin
          if (in_valid) begin
            op_q       <= ric_pkg::op_t'(operation);
            ino_q      <= inode_number;
            mod_q      <= entry_modified;
            nolinks_q  <= no_links;
            hit_found  <= 1'b0;
            free_found <= 1'b0;
            scan_cnt   <= '0;
            res_status <= ric_pkg::ST_IGNORE;
            res_slot   <= '0;
            res_refs   <= '0;
            res_wb     <= 1'b0;
            res_fr     <= 1'b0;
            case (operation)
              ric_pkg::OP_ACQUIRE: begin
                if (!mounted || (inode_number == '0)) begin
                  res_status <= ric_pkg::ST_REJECT;
                  state      <= S_EMIT;
                end else begin
                  state <= S_SCAN;
                end
              end
              ric_pkg::OP_RELEASE: state <= S_SCAN;
              ric_pkg::OP_CLEAR: begin
                clr_pending <= 1'b1;
                state       <= S_SWEEP;
              end
              default: state <= S_EMIT;
            endcase
          end
        end

        S_SCAN: begin
          if (scan_cnt != SCAN_END) begin
            scan_cnt <= scan_cnt + 1'b1;
            rd_pend  <= 1'b1;
            rd_idx   <= scan_cnt[IDX_W-1:0];
          end else if (!rd_pend) begin
            state <= S_UPDATE;
          end
          // Lowest matching valid slot and lowest free slot, both in one pass.
          if (rd_pend) begin
            if (rd_data.valid && (rd_data.inode == ino_q) && !hit_found) begin
              hit_found <= 1'b1;
              hit_idx   <= rd_idx;
              hit_refs  <= rd_data.refs;
            end
            if (!rd_data.valid && !free_found) begin
              free_found <= 1'b1;
              free_idx   <= rd_idx;
            end
          end
        end

        S_UPDATE: begin
          res_status <= upd_status;
          res_slot   <= upd_slot;
          res_refs   <= upd_refs;
          res_wb     <= upd_wb;
          res_fr     <= upd_fr;
          state      <= S_EMIT;
        end

        S_EMIT: begin
          if (!out_valid || out_ready) begin
            out_status <= res_status;
            out_slot   <= slot_wide[ric_pkg::SLOT_W-1:0];
            out_refs   <= res_refs;
            out_wb     <= res_wb;
            out_fr     <= res_fr;
            out_valid  <= 1'b1;
            state      <= S_IDLE;
          end
        end

        default: state <= S_IDLE;
      endcase
    end
  end

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !in_ready)
    else $error("in_ready stayed high after an accepted beat");

  a_sweep_after_reset: assert property (@(posedge clk) disable iff (rst)
    $past(rst) |-> !in_ready)
    else $error("input accepted before the clearing pass");

  a_no_instant_result: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !$rose(out_valid))
    else $error("result appeared in the cycle after its input beat");

  a_held_count: assert property (@(posedge clk) disable iff (rst)
    (out_valid && (out_status == ric_pkg::ST_HIT || out_status == ric_pkg::ST_ALLOC
      || out_status == ric_pkg::ST_HELD)) |-> (out_refs != '0))
    else $error("live entry reported with a zero count");

endmodule
